// ===== rtl/tgad_pkg.sv =====
// Shared types, constants and helper functions of the TGA pixel stream decoder.
`default_nettype none
package tgad_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // Fixed field widths of the configuration and payload.
    localparam int DIM_W   = 13;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
    localparam int ROWI_W  = $clog2(MAX_HEIGHT);
    localparam int INDEX_W = 24;
    localparam int ADDR_W  = 5;

    // Configuration register indexes.
    localparam logic [2:0] REG_WIDTH   = 3'd0;
    localparam logic [2:0] REG_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_FORMAT  = 3'd2;
    localparam logic [2:0] REG_TOPDOWN = 3'd3;
    localparam logic [2:0] REG_PREMULT = 3'd4;

    typedef enum logic [1:0] {
        FMT_GREY8  = 2'd0,
        FMT_BGR24  = 2'd1,
        FMT_BGRA32 = 2'd2,
        FMT_RLE32  = 2'd3
    } t_fmt;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        t_fmt             fmt;
        logic             top_down;
        logic             premult;
    } t_cfg;

    typedef struct packed {
        logic take;
        logic mul;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic emits;
        logic more;
    } t_stat;

    // floor(x / 255) for x up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'({8'd0, x[15:8]}) + 17'd1;
        return t[15:8];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tgad_byte_if.sv =====
// Byte input channel of the decoder.
`default_nettype none
interface tgad_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/tgad_span_if.sv =====
// Span output channel of the decoder.
`default_nettype none
interface tgad_span_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_color;
    logic [23:0] start_index;
    logic [7:0]  span_count;
    logic        run_last;
    logic        image_done;

    modport source (output valid, output pixel_color, output start_index,
                    output span_count, output run_last, output image_done,
                    input ready);
    modport sink (input valid, input pixel_color, input start_index,
                  input span_count, input run_last, input image_done,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/tgad_cfg.sv =====
// APB configuration registers of the decoder.
`default_nettype none
module tgad_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [tgad_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output tgad_pkg::t_cfg                  o_cfg,
    output logic                            o_restart
);

    tgad_pkg::t_cfg r_cfg;
    logic [2:0]     idx;
    logic           wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Any write to a defined register restarts decoding.
    always_comb begin
        o_restart = 1'b0;
        if (wr) begin
            case (idx)
                tgad_pkg::REG_WIDTH, tgad_pkg::REG_HEIGHT, tgad_pkg::REG_FORMAT,
                tgad_pkg::REG_TOPDOWN, tgad_pkg::REG_PREMULT: o_restart = 1'b1;
                default: o_restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width    <= tgad_pkg::DIM_W'(4);
            r_cfg.height   <= tgad_pkg::DIM_W'(1);
            r_cfg.fmt      <= tgad_pkg::FMT_BGRA32;
            r_cfg.top_down <= 1'b0;
            r_cfg.premult  <= 1'b0;
        end else if (wr) begin
            unique case (idx)
                tgad_pkg::REG_WIDTH:   r_cfg.width    <= pwdata[tgad_pkg::DIM_W-1:0];
                tgad_pkg::REG_HEIGHT:  r_cfg.height   <= pwdata[tgad_pkg::DIM_W-1:0];
                tgad_pkg::REG_FORMAT:  r_cfg.fmt      <= tgad_pkg::t_fmt'(pwdata[1:0]);
                tgad_pkg::REG_TOPDOWN: r_cfg.top_down <= pwdata[0];
                tgad_pkg::REG_PREMULT: r_cfg.premult  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            tgad_pkg::REG_WIDTH:   prdata = 32'(r_cfg.width);
            tgad_pkg::REG_HEIGHT:  prdata = 32'(r_cfg.height);
            tgad_pkg::REG_FORMAT:  prdata = 32'(r_cfg.fmt);
            tgad_pkg::REG_TOPDOWN: prdata = 32'(r_cfg.top_down);
            tgad_pkg::REG_PREMULT: prdata = 32'(r_cfg.premult);
            default:               prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/tgad_ctrl.sv =====
// Controller state machine sequencing byte intake, span computation and output.
`default_nettype none
module tgad_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_restart,
    input  wire logic          i_in_valid,
    input  wire logic          i_out_ready,
    input  wire tgad_pkg::t_stat i_stat,
    output tgad_pkg::t_cmd     o_cmd,
    output logic               o_in_ready,
    output logic               o_out_valid
);

    tgad_pkg::t_state r_state;
    tgad_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_state <= tgad_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            tgad_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.emits) n_state = tgad_pkg::ST_MUL;
                end
            end
            tgad_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = tgad_pkg::ST_LOAD;
            end
            tgad_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = tgad_pkg::ST_OUT;
            end
            tgad_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    // A repeat packet continues on the next row.
                    n_state = i_stat.more ? tgad_pkg::ST_MUL : tgad_pkg::ST_IDLE;
                end
            end
            default: n_state = tgad_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/tgad_dp.sv =====
// Datapath: byte assembly, packet tracking, premultiply and span addressing.
`default_nettype none
module tgad_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_restart,
    input  wire tgad_pkg::t_cfg               i_cfg,
    input  wire tgad_pkg::t_cmd               i_cmd,
    input  wire logic [7:0]                   i_byte,
    output tgad_pkg::t_stat                   o_stat,
    output logic      [31:0]                  o_color,
    output logic      [tgad_pkg::INDEX_W-1:0] o_start,
    output logic      [7:0]                   o_count,
    output logic                              o_last,
    output logic                              o_done
);

    localparam int DW = tgad_pkg::DIM_W;
    localparam int CW = tgad_pkg::COL_W;
    localparam int RW = tgad_pkg::ROW_W;
    localparam int IW = tgad_pkg::ROWI_W;
    localparam int XW = tgad_pkg::INDEX_W;

    // Decoder state.
    logic [1:0]    r_phase;
    logic [7:0]    r_blue, r_green, r_red;
    logic [7:0]    r_left;
    logic          r_rep;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          r_fin;

    // Completed pixel and its products.
    logic [7:0]    r_pb, r_pg, r_pr, r_pa;
    logic          r_pm;
    logic [15:0]   r_prod_b, r_prod_g, r_prod_r;
    logic [XW-1:0] r_base;

    // Output payload.
    logic [31:0]   r_color;
    logic [XW-1:0] r_start;
    logic [7:0]    r_count;
    logic          r_last, r_done, r_more;

    logic [DW-1:0]    w_eff, h_eff, room, cnt, col_sum, row_tmp;
    logic [RW-1:0]    row_next;
    logic [IW-1:0]    row_eff;
    logic [IW+DW-1:0] base_prod;
    logic             rep_span, wrap, fin_now;
    logic [7:0]       left_next;
    logic [31:0]      color;

    always_comb begin
        if (i_cfg.width < DW'(4))                       w_eff = DW'(4);
        else if (i_cfg.width > DW'(tgad_pkg::MAX_WIDTH)) w_eff = DW'(tgad_pkg::MAX_WIDTH);
        else                                            w_eff = i_cfg.width;
        if (i_cfg.height < DW'(1))                        h_eff = DW'(1);
        else if (i_cfg.height > DW'(tgad_pkg::MAX_HEIGHT)) h_eff = DW'(tgad_pkg::MAX_HEIGHT);
        else                                              h_eff = i_cfg.height;
    end

    // Whether the byte in front of the intake completes a pixel.
    always_comb begin
        o_stat.emits = 1'b0;
        if (!r_fin) begin
            case (i_cfg.fmt)
                tgad_pkg::FMT_GREY8: o_stat.emits = 1'b1;
                tgad_pkg::FMT_BGR24: o_stat.emits = (r_phase != 2'd0) && (r_phase != 2'd1);
                default: o_stat.emits = (r_phase == 2'd3) &&
                    !(i_cfg.fmt == tgad_pkg::FMT_RLE32 && r_left == 8'd0);
            endcase
        end
        o_stat.more = r_more;
    end

    assign row_tmp   = h_eff - DW'(1) - DW'(r_row);
    assign row_eff   = i_cfg.top_down ? r_row[IW-1:0] : row_tmp[IW-1:0];
    assign base_prod = row_eff * w_eff;

    assign rep_span  = (i_cfg.fmt == tgad_pkg::FMT_RLE32) && r_rep;
    assign room      = w_eff - DW'(r_col);
    assign cnt       = !rep_span ? DW'(1) : ((DW'(r_left) < room) ? DW'(r_left) : room);
    assign col_sum   = DW'(r_col) + cnt;
    assign wrap      = col_sum >= w_eff;
    assign row_next  = r_row + RW'(1);
    assign fin_now   = wrap && (row_next >= RW'(h_eff));
    assign left_next = fin_now ? 8'd0 : (r_left - cnt[7:0]);

    always_comb begin
        if (r_pm) begin
            color = {r_pa, tgad_pkg::div255(r_prod_b), tgad_pkg::div255(r_prod_g),
                     tgad_pkg::div255(r_prod_r)};
        end else begin
            color = {r_pa, r_pb, r_pg, r_pr};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_phase <= 2'd0;
            r_blue  <= 8'd0;
            r_green <= 8'd0;
            r_red   <= 8'd0;
            r_left  <= 8'd0;
            r_rep   <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
            r_fin   <= 1'b0;
            r_more  <= 1'b0;
        end else begin
            if (i_cmd.take && !r_fin) begin
                case (i_cfg.fmt)
                    tgad_pkg::FMT_GREY8: begin
                        r_pb <= i_byte;
                        r_pg <= i_byte;
                        r_pr <= i_byte;
                        r_pa <= i_byte;
                        r_pm <= 1'b0;
                    end
                    tgad_pkg::FMT_BGR24: begin
                        if (r_phase == 2'd0) begin
                            r_blue  <= i_byte;
                            r_phase <= 2'd1;
                        end else if (r_phase == 2'd1) begin
                            r_green <= i_byte;
                            r_phase <= 2'd2;
                        end else begin
                            r_phase <= 2'd0;
                            r_pb    <= r_blue;
                            r_pg    <= r_green;
                            r_pr    <= i_byte;
                            r_pa    <= 8'hFF;
                            r_pm    <= 1'b0;
                        end
                    end
                    default: begin
                        if (i_cfg.fmt == tgad_pkg::FMT_RLE32 && r_left == 8'd0) begin
                            // Packet header: count in the low seven bits.
                            r_left  <= {1'b0, i_byte[6:0]} + 8'd1;
                            r_rep   <= i_byte[7];
                            r_phase <= 2'd0;
                        end else if (r_phase == 2'd0) begin
                            r_blue  <= i_byte;
                            r_phase <= 2'd1;
                        end else if (r_phase == 2'd1) begin
                            r_green <= i_byte;
                            r_phase <= 2'd2;
                        end else if (r_phase == 2'd2) begin
                            r_red   <= i_byte;
                            r_phase <= 2'd3;
                        end else begin
                            r_phase <= 2'd0;
                            r_pb    <= r_blue;
                            r_pg    <= r_green;
                            r_pr    <= r_red;
                            r_pa    <= i_byte;
                            r_pm    <= i_cfg.premult;
                        end
                    end
                endcase
            end
            if (i_cmd.load) begin
                if (wrap) begin
                    r_col <= '0;
                    r_row <= row_next;
                end else begin
                    r_col <= col_sum[CW-1:0];
                end
                if (fin_now) r_fin <= 1'b1;
                if (i_cfg.fmt == tgad_pkg::FMT_RLE32) r_left <= left_next;
                r_more <= rep_span && (left_next != 8'd0) && !fin_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod_b <= r_pb * r_pa;
            r_prod_g <= r_pg * r_pa;
            r_prod_r <= r_pr * r_pa;
            r_base   <= base_prod[XW-1:0];
        end
        if (i_cmd.load) begin
            r_color <= color;
            r_start <= r_base + XW'(r_col);
            r_count <= cnt[7:0];
            r_last  <= !(rep_span && (left_next != 8'd0) && !fin_now);
            r_done  <= fin_now;
        end
    end

    assign o_color = r_color;
    assign o_start = r_start;
    assign o_count = r_count;
    assign o_last  = r_last;
    assign o_done  = r_done;

endmodule
`default_nettype wire

// ===== rtl/tga_pixel_stream_decoder.sv =====
// Top level of the TGA pixel stream decoder.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+------------------------------------------
//  i_byte    | in  | valid/ready        | data_byte
//  o_span    | out | valid/ready        | pixel_color, start_index, span_count,
//            |     |                    | run_last, image_done
//  APB       | in  | psel/penable/pready| 5 registers at byte addresses 0..16
//
// A byte that completes no pixel is taken while the intake stays ready. A byte
// that completes a pixel is taken, the multiply state then does alpha and row
// multiplies, the load state forms the span, and the output state offers it.
// Each further row span of a repeat packet passes through the same multiply and
// load states. Reset is synchronous; any write to a defined register restarts
// the image. While a span waits for a transfer, the byte input is held off.
`default_nettype none
module tga_pixel_stream_decoder (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    tgad_byte_if.sink                         i_byte,
    tgad_span_if.source                       o_span,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tgad_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    tgad_pkg::t_cfg  cfg;
    tgad_pkg::t_cmd  cmd;
    tgad_pkg::t_stat stat;
    logic            restart;

    tgad_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (cfg),
        .o_restart (restart)
    );

    tgad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (restart),
        .i_in_valid  (i_byte.valid),
        .i_out_ready (o_span.ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_ready  (i_byte.ready),
        .o_out_valid (o_span.valid)
    );

    tgad_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_cfg     (cfg),
        .i_cmd     (cmd),
        .i_byte    (i_byte.data_byte),
        .o_stat    (stat),
        .o_color   (o_span.pixel_color),
        .o_start   (o_span.start_index),
        .o_count   (o_span.span_count),
        .o_last    (o_span.run_last),
        .o_done    (o_span.image_done)
    );

endmodule
`default_nettype wire
